FILE: rtl/hsrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsrc_pkg
// Shared types and constants for the hardware-monitor raw reading converter.
// ----------------------------------------------------------------------------
package hsrc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT_TEMP_MODEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TABLE_MODE        = 1'd1;

    localparam logic [1:0] ACT_TEMP = 2'd0;
    localparam logic [1:0] ACT_VOLT = 2'd1;
    localparam logic [1:0] ACT_TACH = 2'd2;

    localparam logic [1:0] TABLE_SIGN_HIGH = 2'd2;
    localparam logic [1:0] TABLE_SIGN_LOW  = 2'd3;

    localparam logic [2:0] CH_VCORE = 3'd0;
    localparam logic [2:0] CH_HALF  = 3'd1;

    localparam logic [7:0] TEMP_INVALID_A = 8'hBB;
    localparam logic [7:0] TEMP_INVALID_B = 8'hCC;

    localparam int DIV_W      = 12;
    localparam int DIV_STAGES = 5;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_Q_W    = DIV_STAGES * DIV_STEPS;

    localparam logic [15:0]      TACH_LIMIT     = 16'h0FFF;
    localparam logic [15:0]      TACH_SAT_COUNT = 16'd45;
    localparam logic [20:0]      TACH_NUM       = 21'd1500000;
    localparam logic [DIV_W-1:0] TACH_REM_INIT  = DIV_W'(TACH_NUM >> DIV_Q_W);
    localparam logic [15:0]      RESULT_MAX     = 16'd32767;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] channel;
        logic [7:0] raw_high;
        logic [7:0] raw_low;
    } sensor_in_t;

    typedef struct packed {
        logic signed [15:0] converted;
        logic        [7:0]  core_voltage_raw;
    } sensor_out_t;

    typedef struct packed {
        logic       sixteen_bit_temp_model;
        logic [1:0] temp_table_mode;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        base;
        logic               is_div;
        logic [7:0]         vcore;
        logic [DIV_W-1:0]   divisor;
        logic [DIV_W-1:0]   rem;
        logic [DIV_Q_W-1:0] quo;
    } pipe_t;

endpackage
`default_nettype wire

FILE: rtl/hsrc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsrc_front
// Input stage: decodes the transaction, converts temperature and voltage,
// sets up the tachometer division and holds the captured core-voltage byte.
// ----------------------------------------------------------------------------
module hsrc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire hsrc_pkg::sensor_in_t up_data,
    input  wire hsrc_pkg::cfg_t      cfg,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output hsrc_pkg::pipe_t          dn_data
);
    import hsrc_pkg::*;

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic [7:0]  vcore_reg;
    logic [7:0]  vcore_next;
    logic        fire;
    logic        capture;
    logic [15:0] count;
    logic        tach_zero;
    logic        tach_sat;
    logic        sign;
    logic        round_up;
    logic [15:0] temp16;
    logic [15:0] base;

    assign up_ready = !valid_reg || dn_ready;
    assign fire     = up_valid && up_ready;
    assign capture  = (up_data.action == ACT_VOLT) && (up_data.channel == CH_VCORE);
    assign count    = {up_data.raw_high, up_data.raw_low};
    assign tach_zero = (count == 16'd0) || (count >= TACH_LIMIT);
    assign tach_sat  = !tach_zero && (count <= TACH_SAT_COUNT);

    always_comb
    begin
        priority if (cfg.temp_table_mode == TABLE_SIGN_HIGH)
            sign = up_data.raw_high[7];
        else if (cfg.temp_table_mode == TABLE_SIGN_LOW)
            sign = up_data.raw_low[0];
        else
            sign = 1'b0;
    end

    // truncate toward zero: negative values with dropped fraction move up by one
    assign round_up = sign && (up_data.raw_low[7:5] != 3'd0);
    assign temp16   = {{7{sign}}, sign, up_data.raw_high} + {15'd0, round_up};

    always_comb
    begin
        unique case (up_data.action)
            ACT_TEMP:
            begin
                if (!cfg.sixteen_bit_temp_model)
                    base = {8'd0, up_data.raw_high};
                else if (up_data.raw_high == TEMP_INVALID_A ||
                         up_data.raw_high == TEMP_INVALID_B)
                    base = 16'd0;
                else
                    base = temp16;
            end
            ACT_VOLT:
            begin
                if (up_data.channel == CH_HALF)
                    base = {5'd0, up_data.raw_high, 3'd0};
                else
                    base = {4'd0, up_data.raw_high, 4'd0};
            end
            ACT_TACH:
                base = tach_sat ? RESULT_MAX : 16'd0;
            default:
                base = 16'd0;
        endcase
    end

    assign vcore_next = (fire && capture) ? up_data.raw_high : vcore_reg;

    always_comb
    begin
        data_next.base    = base;
        data_next.is_div  = (up_data.action == ACT_TACH) && !tach_zero && !tach_sat;
        data_next.vcore   = capture ? up_data.raw_high : vcore_reg;
        data_next.divisor = count[DIV_W-1:0];
        data_next.rem     = TACH_REM_INIT;
        data_next.quo     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vcore_reg <= 8'd0;
        end
        else
        begin
            vcore_reg <= vcore_next;
            if (up_ready)
                valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

`ifndef SYNTHESIS
    a_vcore_only_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(vcore_reg) |-> $past(fire && capture))
        else $error("core voltage byte changed without a channel 0 voltage transaction");

    a_div_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.is_div |-> {4'd0, data_reg.divisor} > TACH_SAT_COUNT)
        else $error("divider entered with a saturating divisor");
`endif

endmodule
`default_nettype wire

FILE: rtl/hsrc_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsrc_div_stage
// One register stage of the tachometer divider: three restoring division
// steps on the running remainder, with its own valid bit and stall.
// ----------------------------------------------------------------------------
module hsrc_div_stage (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [hsrc_pkg::DIV_STEPS-1:0]   num_bits,
    input  wire logic                             up_valid,
    output logic                                  up_ready,
    input  wire hsrc_pkg::pipe_t                  up_data,
    output logic                                  dn_valid,
    input  wire logic                             dn_ready,
    output hsrc_pkg::pipe_t                       dn_data
);
    import hsrc_pkg::*;

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        logic [DIV_W:0] trial;
        logic           ge;
        data_next = up_data;
        for (int i = DIV_STEPS - 1; i >= 0; i--)
        begin
            trial = {data_next.rem, num_bits[i]};
            ge    = trial >= {1'b0, data_next.divisor};
            data_next.rem = ge ? DIV_W'(trial - {1'b0, data_next.divisor})
                               : trial[DIV_W-1:0];
            data_next.quo = {data_next.quo[DIV_Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.is_div |-> data_reg.rem < data_reg.divisor)
        else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

FILE: rtl/hwmon_sensor_raw_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hwmon_sensor_raw_converter_unit
// Converts raw hardware-monitor register bytes into temperature, voltage and
// tachometer readings.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while the output side is not
// stalled and returns one result for each, in order. The pipeline depth is
// set by the tachometer divide of 1500000 by the low 12 bits of the count:
// an input stage, five divider stages of three quotient bits each, and the
// output register. Temperature and voltage results ride the same pipeline
// so ordering is kept. Configuration writes are accepted every cycle and
// take effect for transactions accepted afterwards.
module hwmon_sensor_raw_converter_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire hsrc_pkg::sensor_in_t              in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output hsrc_pkg::sensor_out_t                  out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hsrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hsrc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hsrc_pkg::*;

    cfg_t        cfg_reg;
    logic        stg_valid [0:DIV_STAGES];
    logic        stg_ready [0:DIV_STAGES];
    pipe_t       stg_data  [0:DIV_STAGES];
    logic        out_valid_reg;
    sensor_out_t out_data_reg;
    sensor_out_t out_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SIXTEEN_BIT_TEMP_MODEL: cfg_reg.sixteen_bit_temp_model <= cfg_data[0];
                CFG_TEMP_TABLE_MODE:        cfg_reg.temp_table_mode <= cfg_data;
            endcase
        end
    end

    hsrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_data  (in_data),
        .cfg      (cfg_reg),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_data  (stg_data[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        hsrc_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .num_bits (TACH_NUM[DIV_Q_W-1-k*DIV_STEPS -: DIV_STEPS]),
            .up_valid (stg_valid[k]),
            .up_ready (stg_ready[k]),
            .up_data  (stg_data[k]),
            .dn_valid (stg_valid[k+1]),
            .dn_ready (stg_ready[k+1]),
            .dn_data  (stg_data[k+1])
        );
    end

    assign stg_ready[DIV_STAGES] = !out_valid_reg || out_ready;

    always_comb
    begin
        out_data_next.converted = stg_data[DIV_STAGES].is_div
                                ? $signed({1'b0, stg_data[DIV_STAGES].quo})
                                : $signed(stg_data[DIV_STAGES].base);
        out_data_next.core_voltage_raw = stg_data[DIV_STAGES].vcore;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stg_ready[DIV_STAGES])
            out_valid_reg <= stg_valid[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (stg_valid[DIV_STAGES] && stg_ready[DIV_STAGES])
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_converted_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.converted >= -16'sd256)
        else $error("converted value below temperature range");

    a_quotient_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[DIV_STAGES] && stg_data[DIV_STAGES].is_div
            |-> {1'b0, stg_data[DIV_STAGES].quo} <= RESULT_MAX)
        else $error("tachometer quotient above saturation limit");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_hwmon_sensor_raw_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_hwmon_sensor_raw_converter_unit
// Self-checking bench for the raw reading converter. A short table of
// directed readings (register extremes, invalid temperature codes, sign
// sources, tachometer limits and saturation, core-voltage capture, the
// undefined action) runs first, then random readings under several register
// settings. Both handshakes idle at random. Every result is compared field by
// field against an in-bench model of the conversions or a row's given value.
// ----------------------------------------------------------------------------
module tb_hwmon_sensor_raw_converter_unit;
    import hsrc_pkg::*;

    localparam logic [1:0] ACT_UNDEF = 2'd3;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_READINGS = 80;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic        model;
        logic [1:0]  mode;
        sensor_in_t  reading;
        bit          typed;
        logic signed [15:0] conv;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    sensor_in_t  in_data;
    logic        out_valid;
    logic        out_ready;
    sensor_out_t out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                 drv_typed;
    logic signed [15:0] drv_typed_conv;

    logic       model_sixteen = 1'b0;
    logic [1:0] model_table = 2'd0;
    logic [7:0] model_vcore = 8'd0;

    sensor_out_t awaited_readings[$];
    stim_row_t   stim_table[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_quiet = 0;
    int          recv_quiet = 0;
    logic        cur_model = 1'b0;
    logic [1:0]  cur_mode = 2'd0;

    hwmon_sensor_raw_converter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_hwmon_sensor_raw_converter_unit: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < 50)
            $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic int draw_gap(inout int quiet);
        int gap;
        if (quiet > 0)
        begin
            quiet--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
                quiet = $urandom_range(10, 40);
        end
        return gap;
    endfunction

    function automatic logic signed [15:0] convert_temperature(logic [7:0] hi, logic [7:0] lo);
        logic        sign;
        logic [15:0] word;
        int          value;
        if (!model_sixteen)
            return {8'd0, hi};
        if (hi == TEMP_INVALID_A || hi == TEMP_INVALID_B)
            return 16'sd0;
        sign = 1'b0;
        if (model_table == TABLE_SIGN_HIGH)
            sign = hi[7];
        else if (model_table == TABLE_SIGN_LOW)
            sign = lo[0];
        word = {sign, hi, lo[7:5], 4'b0000};
        value = $signed(word);
        return 16'(value / 128);
    endfunction

    function automatic logic signed [15:0] convert_tach(logic [7:0] hi, logic [7:0] lo);
        int unsigned count;
        int unsigned rpm;
        count = {hi, lo};
        if (count == 0 || count >= TACH_LIMIT)
            return 16'sd0;
        rpm = TACH_NUM / count;
        if (rpm > RESULT_MAX)
            rpm = RESULT_MAX;
        return rpm[15:0];
    endfunction

    function automatic sensor_out_t predict_reading(sensor_in_t rd);
        sensor_out_t res;
        res.converted = 16'sd0;
        case (rd.action)
            ACT_TEMP: res.converted = convert_temperature(rd.raw_high, rd.raw_low);
            ACT_VOLT:
            begin
                if (rd.channel == CH_VCORE)
                    model_vcore = rd.raw_high;
                if (rd.channel == CH_HALF)
                    res.converted = {5'd0, rd.raw_high, 3'd0};
                else
                    res.converted = {4'd0, rd.raw_high, 4'd0};
            end
            ACT_TACH: res.converted = convert_tach(rd.raw_high, rd.raw_low);
            default: res.converted = 16'sd0;
        endcase
        res.core_voltage_raw = model_vcore;
        return res;
    endfunction

    // transaction monitor: accepted readings, returned results and config
    always @(posedge clk)
    begin
        sensor_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_readings.size() == 0)
                    report_mismatch($sformatf("unexpected result converted %0d vcore %0d",
                                              out_data.converted, out_data.core_voltage_raw));
                else
                begin
                    want = awaited_readings.pop_front();
                    if (out_data.converted !== want.converted)
                        report_mismatch($sformatf("converted got %0d expected %0d",
                                                  out_data.converted, want.converted));
                    if (out_data.core_voltage_raw !== want.core_voltage_raw)
                        report_mismatch($sformatf("core_voltage_raw got %0d expected %0d",
                                                  out_data.core_voltage_raw,
                                                  want.core_voltage_raw));
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_reading(in_data);
                if (drv_typed)
                    want.converted = drv_typed_conv;
                awaited_readings.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SIXTEEN_BIT_TEMP_MODEL)
                    model_sixteen = cfg_data[0];
                else if (cfg_index == CFG_TEMP_TABLE_MODE)
                    model_table = cfg_data;
            end
        end
    end

    // result side: random stalls per transaction
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(recv_quiet);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_reading(input sensor_in_t rd, input bit typed,
                                input logic signed [15:0] conv);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_data        <= rd;
        drv_typed      <= typed;
        drv_typed_conv <= conv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic model, input logic [1:0] mode);
        for (int idx = 0; idx < 2; idx++)
        begin
            cfg_valid <= 1'b1;
            if (idx == 0)
            begin
                cfg_index <= CFG_SIXTEEN_BIT_TEMP_MODEL;
                cfg_data  <= {1'b0, model};
            end
            else
            begin
                cfg_index <= CFG_TEMP_TABLE_MODE;
                cfg_data  <= mode;
            end
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_model = model;
        cur_mode  = mode;
    endtask

    task automatic add_row(input logic model, input logic [1:0] mode, input logic [1:0] act,
                           input logic [2:0] ch, input logic [7:0] hi, input logic [7:0] lo,
                           input bit typed, input logic signed [15:0] conv);
        stim_row_t row;
        row.model   = model;
        row.mode    = mode;
        row.reading = '{action: act, channel: ch, raw_high: hi, raw_low: lo};
        row.typed   = typed;
        row.conv    = conv;
        stim_table.push_back(row);
    endtask

    function automatic sensor_in_t random_reading();
        sensor_in_t  rd;
        logic [15:0] count;
        rd.action   = ($urandom_range(0, 19) == 0) ? ACT_UNDEF
                                                   : 2'($urandom_range(ACT_TEMP, ACT_TACH));
        rd.channel  = 3'($urandom_range(0, 7));
        rd.raw_high = 8'($urandom);
        rd.raw_low  = 8'($urandom);
        if (rd.action == ACT_TEMP && $urandom_range(0, 7) == 0)
            rd.raw_high = $urandom_range(0, 1) ? TEMP_INVALID_A : TEMP_INVALID_B;
        if (rd.action == ACT_TACH)
        begin
            case ($urandom_range(0, 3))
                0: count = 16'($urandom_range(1, 64));
                1: count = 16'($urandom_range(65, 16'h0FFE));
                2: count = 16'($urandom);
                default: count = $urandom_range(0, 3) == 0 ? 16'd0
                                                         : 16'($urandom_range(16'h0FF0, 16'h1010));
            endcase
            {rd.raw_high, rd.raw_low} = count;
        end
        return rd;
    endfunction

    initial
    begin
        logic       phase_model[RANDOM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        logic [1:0] phase_mode[RANDOM_PHASES]  = '{2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3};
        logic       model;
        logic [1:0] mode;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        out_ready      <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        drv_typed      <= 1'b0;
        drv_typed_conv <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain byte temperatures, voltages, tachometer limits
        add_row(1'b0, 2'd0, ACT_TEMP, 3'd2, 8'h00, 8'h00, 1, 16'sd0);
        add_row(1'b0, 2'd0, ACT_TEMP, 3'd7, 8'hFF, 8'hFF, 1, 16'sd255);
        add_row(1'b0, 2'd0, ACT_VOLT, CH_VCORE, 8'hFF, 8'h00, 1, 16'sd4080);
        add_row(1'b0, 2'd0, ACT_VOLT, CH_HALF, 8'hFF, 8'hFF, 1, 16'sd2040);
        add_row(1'b0, 2'd0, ACT_VOLT, 3'd7, 8'h00, 8'hFF, 1, 16'sd0);
        add_row(1'b0, 2'd0, ACT_VOLT, CH_VCORE, 8'h5A, 8'h33, 0, 16'sd0);
        add_row(1'b0, 2'd0, ACT_TACH, 3'd3, 8'h00, 8'h00, 1, 16'sd0);
        add_row(1'b0, 2'd0, ACT_TACH, 3'd4, 8'h0F, 8'hFF, 1, 16'sd0);
        add_row(1'b0, 2'd0, ACT_TACH, 3'd5, 8'hFF, 8'hFF, 1, 16'sd0);
        add_row(1'b0, 2'd0, ACT_TACH, 3'd6, 8'h00, 8'h01, 1, 16'sd32767);
        add_row(1'b0, 2'd0, ACT_TACH, 3'd1, 8'h00, 8'h2D, 1, 16'sd32767);
        add_row(1'b0, 2'd0, ACT_TACH, 3'd0, 8'h00, 8'h2E, 0, 16'sd0);
        add_row(1'b0, 2'd0, ACT_TACH, 3'd2, 8'h0F, 8'hFE, 0, 16'sd0);
        add_row(1'b0, 2'd0, ACT_UNDEF, CH_VCORE, 8'hFF, 8'hFF, 1, 16'sd0);
        // 16-bit temperatures: invalid codes and each sign source
        add_row(1'b1, 2'd0, ACT_TEMP, 3'd0, TEMP_INVALID_A, 8'h00, 1, 16'sd0);
        add_row(1'b1, 2'd0, ACT_TEMP, 3'd0, TEMP_INVALID_B, 8'hFF, 1, 16'sd0);
        add_row(1'b1, 2'd0, ACT_TEMP, 3'd0, 8'hFF, 8'hFF, 1, 16'sd255);
        add_row(1'b1, 2'd0, ACT_TEMP, 3'd0, 8'h00, 8'hE0, 0, 16'sd0);
        add_row(1'b1, 2'd2, ACT_TEMP, 3'd0, 8'h80, 8'h00, 0, 16'sd0);
        add_row(1'b1, 2'd2, ACT_TEMP, 3'd0, 8'hFF, 8'hE0, 0, 16'sd0);
        add_row(1'b1, 2'd3, ACT_TEMP, 3'd0, 8'h00, 8'h01, 1, -16'sd256);
        add_row(1'b1, 2'd3, ACT_TEMP, 3'd0, 8'h7F, 8'hE1, 0, 16'sd0);
        add_row(1'b1, 2'd1, ACT_TEMP, 3'd0, 8'h40, 8'h21, 0, 16'sd0);

        foreach (stim_table[i])
        begin
            if (stim_table[i].model !== cur_model || stim_table[i].mode !== cur_mode)
            begin
                wait_drained();
                write_config(stim_table[i].model, stim_table[i].mode);
            end
            send_reading(stim_table[i].reading, stim_table[i].typed, stim_table[i].conv);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            model = phase_model[p];
            mode  = phase_mode[p];
            if (p == RANDOM_PHASES - 1)
            begin
                model = 1'($urandom);
                mode  = 2'($urandom);
            end
            wait_drained();
            write_config(model, mode);
            repeat (PHASE_READINGS)
            begin
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
                send_reading(random_reading(), 1'b0, 16'sd0);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && awaited_readings.size() == 0)
            $display("tb_hwmon_sensor_raw_converter_unit: PASS");
        else
            $display("tb_hwmon_sensor_raw_converter_unit: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: hwmon_sensor_raw_converter_unit.f
rtl/hsrc_pkg.sv
rtl/hsrc_front.sv
rtl/hsrc_div_stage.sv
rtl/hwmon_sensor_raw_converter_unit.sv
bench/tb_hwmon_sensor_raw_converter_unit.sv
